### rtl/core/awd_pkg.sv
// Package for the anagram window detector: sizes, function codes and the
// item, operation and histogram-bin types shared by the modules that import it.
// No dependencies.
package awd_pkg;

  // Sizing.
  localparam int PATTERN_MAX  = 64;
  localparam int ALPHABET     = 26;
  localparam int SYM_W        = 5;
  localparam int CNT_W        = $clog2(PATTERN_MAX + 1);
  localparam int BIN_AW       = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int MISS_W       = $clog2(ALPHABET + 1);
  localparam int RECENT_AW    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int RECENT_DEPTH = 1 << RECENT_AW;
  localparam int OUTQ_DEPTH   = 4;
  localparam int OUTQ_AW      = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW      = $clog2(OUTQ_DEPTH + 1);

  // Function codes of an input item.
  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_PATTERN = 2'd1,
    FUNC_TEXT    = 2'd2
  } awd_func_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [SYM_W-1:0] symbol;
  } awd_in_t;

  typedef struct packed {
    logic match;
    logic found;
    logic pattern_overflow;
  } awd_out_t;

  // Decoded operation that travels down the pipeline with each item.
  typedef struct packed {
    logic              clr;   // clear everything
    logic              pat;   // pattern symbol taken into the histogram
    logic              txt;   // text symbol that updates the window
    logic              rem;   // the oldest window symbol leaves
    logic              chk;   // text symbol in the alphabet, result is checked
    logic              full;  // window is full after this item
    logic              ovf;   // sticky overflow flag after this item
    logic [BIN_AW-1:0] sym;
  } awd_op_t;

  // One histogram bin: pattern count and running count of text symbols in.
  typedef struct packed {
    logic [CNT_W-1:0] pc;
    logic [CNT_W-1:0] in_cnt;
  } awd_bin_t;

endpackage

### rtl/core/awd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read of the address being written returns the old contents. No dependencies.
module awd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/awd_front.sv
// Front stage: decodes accepted items, keeps pattern length, window fill and
// the text delay line (a circular buffer in awd_ram). Uses awd_pkg.
module awd_front import awd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  awd_in_t           item_i,
  output logic              op_valid_o,
  output awd_op_t           op_o,
  output logic [BIN_AW-1:0] old_o
);

  logic [CNT_W-1:0]     len_q, len_d;
  logic [CNT_W-1:0]     seen_q, seen_d;
  logic [RECENT_AW-1:0] wp_q, wp_d;
  logic                 ovf_q, ovf_d;
  logic                 p1_v_q;
  awd_op_t              p1_op_q, op_d;
  logic                 sym_ok;
  logic                 rt_we;
  logic [RECENT_AW-1:0] rt_raddr;

  assign sym_ok = (32'(item_i.symbol) < ALPHABET);

  always_comb begin
    len_d     = len_q;
    seen_d    = seen_q;
    wp_d      = wp_q;
    ovf_d     = ovf_q;
    rt_we     = 1'b0;
    op_d      = '0;
    op_d.sym  = sym_ok ? BIN_AW'(item_i.symbol) : '0;
    if (acc_i) begin
      unique case (item_i.func)
        FUNC_CLEAR: begin
          len_d    = '0;
          seen_d   = '0;
          ovf_d    = 1'b0;
          op_d.clr = 1'b1;
        end
        FUNC_PATTERN: begin
          if (sym_ok) begin
            if (len_q >= CNT_W'(PATTERN_MAX)) begin
              ovf_d = 1'b1;
            end else begin
              len_d    = len_q + CNT_W'(1);
              seen_d   = '0;
              op_d.pat = 1'b1;
            end
          end
        end
        FUNC_TEXT: begin
          if (sym_ok) begin
            op_d.chk = 1'b1;
            if (len_q != '0) begin
              op_d.txt = 1'b1;
              op_d.rem = (seen_q >= len_q);
              rt_we    = 1'b1;
              wp_d     = wp_q + RECENT_AW'(1);
              if (seen_q < len_q) begin
                seen_d = seen_q + CNT_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
    op_d.full = (seen_d >= len_d);
    op_d.ovf  = ovf_d;
  end

  // The symbol leaving the window was written len_q text symbols ago.
  assign rt_raddr = wp_q - RECENT_AW'(len_q);

  awd_ram #(
    .WIDTH (BIN_AW),
    .DEPTH (RECENT_DEPTH)
  ) u_recent_ram (
    .clk_i   (clk_i),
    .we_i    (rt_we),
    .waddr_i (wp_q),
    .wdata_i (op_d.sym),
    .raddr_i (rt_raddr),
    .rdata_o (old_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      seen_q <= '0;
      wp_q   <= '0;
      ovf_q  <= 1'b0;
      p1_v_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      seen_q <= seen_d;
      wp_q   <= wp_d;
      ovf_q  <= ovf_d;
      p1_v_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_op_q <= op_d;
  end

  assign op_valid_o = p1_v_q;
  assign op_o       = p1_op_q;

  a_seen_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= len_q)
    else $error("window fill exceeds pattern length");

endmodule

### rtl/core/awd_hist.sv
// Histogram stage: pattern, text-in and text-out counts in awd_ram copies,
// read-modify-write with forwarding, mismatch tracking and result flags.
// Uses awd_pkg and awd_ram.
module awd_hist import awd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  input  awd_op_t           op_i,
  input  logic [BIN_AW-1:0] old_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output awd_out_t          res_o
);

  logic [BIN_AW-1:0]   sa, oa;
  logic                p2_v_q;
  awd_op_t             p2_op_q;
  logic [BIN_AW-1:0]   p2_sa_q, p2_oa_q;

  logic [ALPHABET-1:0] pat_vld_q, pat_vld_d;
  logic [ALPHABET-1:0] in_vld_q, in_vld_d;
  logic [ALPHABET-1:0] out_vld_q, out_vld_d;
  logic [MISS_W-1:0]   mis_q, mis_d;
  logic [MISS_W-1:0]   dist_q, dist_d;
  logic                found_q, found_d;

  logic                bfw_v_q;
  logic [BIN_AW-1:0]   bfw_a_q;
  awd_bin_t            bfw_d_q;
  logic                ofw_v_q;
  logic [BIN_AW-1:0]   ofw_a_q;
  logic [CNT_W-1:0]    ofw_d_q;

  awd_bin_t            bin_s_raw, bin_o_raw, bin_s, bin_o, bin_wd;
  logic [CNT_W-1:0]    out_s_raw, out_o_raw, out_s, out_o, out_wd;
  logic                bin_we, out_we;
  logic [CNT_W-1:0]    wc_s, wc_o, wc_s_inc, wc_o_dec;
  logic                eq_s0, eq_s1, eq_o0, eq_o1, same_bin, match;

  // Read addresses; inactive items read bin zero.
  assign sa = (op_valid_i && (op_i.pat || op_i.txt)) ? op_i.sym : '0;
  assign oa = (op_valid_i && op_i.rem) ? old_i : '0;

  awd_ram #(.WIDTH($bits(awd_bin_t)), .DEPTH(ALPHABET)) u_bin_s_ram (
    .clk_i (clk_i), .we_i (bin_we), .waddr_i (p2_sa_q), .wdata_i (bin_wd),
    .raddr_i (sa), .rdata_o (bin_s_raw)
  );

  awd_ram #(.WIDTH($bits(awd_bin_t)), .DEPTH(ALPHABET)) u_bin_o_ram (
    .clk_i (clk_i), .we_i (bin_we), .waddr_i (p2_sa_q), .wdata_i (bin_wd),
    .raddr_i (oa), .rdata_o (bin_o_raw)
  );

  awd_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET)) u_out_s_ram (
    .clk_i (clk_i), .we_i (out_we), .waddr_i (p2_oa_q), .wdata_i (out_wd),
    .raddr_i (sa), .rdata_o (out_s_raw)
  );

  awd_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET)) u_out_o_ram (
    .clk_i (clk_i), .we_i (out_we), .waddr_i (p2_oa_q), .wdata_i (out_wd),
    .raddr_i (oa), .rdata_o (out_o_raw)
  );

  // Resolve read data: the write of the previous cycle wins, otherwise a
  // bin whose valid bit is clear reads as zero.
  always_comb begin
    if (bfw_v_q && (bfw_a_q == p2_sa_q)) begin
      bin_s = bfw_d_q;
    end else begin
      bin_s.pc     = pat_vld_q[p2_sa_q] ? bin_s_raw.pc : '0;
      bin_s.in_cnt = in_vld_q[p2_sa_q] ? bin_s_raw.in_cnt : '0;
    end
    if (bfw_v_q && (bfw_a_q == p2_oa_q)) begin
      bin_o = bfw_d_q;
    end else begin
      bin_o.pc     = pat_vld_q[p2_oa_q] ? bin_o_raw.pc : '0;
      bin_o.in_cnt = in_vld_q[p2_oa_q] ? bin_o_raw.in_cnt : '0;
    end
    if (ofw_v_q && (ofw_a_q == p2_sa_q)) begin
      out_s = ofw_d_q;
    end else begin
      out_s = out_vld_q[p2_sa_q] ? out_s_raw : '0;
    end
    if (ofw_v_q && (ofw_a_q == p2_oa_q)) begin
      out_o = ofw_d_q;
    end else begin
      out_o = out_vld_q[p2_oa_q] ? out_o_raw : '0;
    end
  end

  // Window count of a bin is symbols in minus symbols out, modulo the width.
  assign wc_s     = bin_s.in_cnt - out_s;
  assign wc_o     = bin_o.in_cnt - out_o;
  assign wc_s_inc = wc_s + CNT_W'(1);
  assign wc_o_dec = wc_o - CNT_W'(1);
  assign eq_s0    = (wc_s == bin_s.pc);
  assign eq_s1    = (wc_s_inc == bin_s.pc);
  assign eq_o0    = (wc_o == bin_o.pc);
  assign eq_o1    = (wc_o_dec == bin_o.pc);
  assign same_bin = p2_op_q.rem && (p2_sa_q == p2_oa_q);

  always_comb begin
    pat_vld_d     = pat_vld_q;
    in_vld_d      = in_vld_q;
    out_vld_d     = out_vld_q;
    mis_d         = mis_q;
    dist_d        = dist_q;
    found_d       = found_q;
    bin_we        = 1'b0;
    out_we        = 1'b0;
    bin_wd.pc     = bin_s.pc;
    bin_wd.in_cnt = bin_s.in_cnt + CNT_W'(1);
    out_wd        = out_o + CNT_W'(1);
    match         = 1'b0;
    if (p2_v_q) begin
      if (p2_op_q.clr) begin
        pat_vld_d = '0;
        in_vld_d  = '0;
        out_vld_d = '0;
        mis_d     = '0;
        dist_d    = '0;
      end else if (p2_op_q.pat) begin
        // New pattern symbol; the window restarts empty, so every bin with
        // a nonzero pattern count mismatches.
        bin_we              = 1'b1;
        bin_wd.pc           = bin_s.pc + CNT_W'(1);
        bin_wd.in_cnt       = '0;
        dist_d              = dist_q + MISS_W'(bin_s.pc == '0);
        mis_d               = dist_d;
        in_vld_d            = '0;
        out_vld_d           = '0;
        pat_vld_d[p2_sa_q]  = 1'b1;
        in_vld_d[p2_sa_q]   = 1'b1;
      end else if (p2_op_q.txt) begin
        bin_we             = 1'b1;
        pat_vld_d[p2_sa_q] = 1'b1;
        in_vld_d[p2_sa_q]  = 1'b1;
        if (p2_op_q.rem) begin
          out_we             = 1'b1;
          out_vld_d[p2_oa_q] = 1'b1;
        end
        // When the incoming and outgoing symbol are the same letter the
        // window histogram does not change.
        if (!same_bin) begin
          if (eq_s0 && !eq_s1) begin
            mis_d = mis_d + MISS_W'(1);
          end else if (!eq_s0 && eq_s1) begin
            mis_d = mis_d - MISS_W'(1);
          end
          if (p2_op_q.rem) begin
            if (eq_o0 && !eq_o1) begin
              mis_d = mis_d + MISS_W'(1);
            end else if (!eq_o0 && eq_o1) begin
              mis_d = mis_d - MISS_W'(1);
            end
          end
        end
      end
      match = p2_op_q.chk && p2_op_q.full && (mis_d == '0);
      if (p2_op_q.clr) begin
        found_d = 1'b0;
      end else begin
        found_d = found_q | match;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q    <= 1'b0;
      pat_vld_q <= '0;
      in_vld_q  <= '0;
      out_vld_q <= '0;
      mis_q     <= '0;
      dist_q    <= '0;
      found_q   <= 1'b0;
      bfw_v_q   <= 1'b0;
      ofw_v_q   <= 1'b0;
    end else begin
      p2_v_q    <= op_valid_i;
      pat_vld_q <= pat_vld_d;
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      mis_q     <= mis_d;
      dist_q    <= dist_d;
      found_q   <= found_d;
      bfw_v_q   <= bin_we;
      ofw_v_q   <= out_we;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_op_q <= op_i;
    p2_sa_q <= sa;
    p2_oa_q <= oa;
    bfw_a_q <= p2_sa_q;
    bfw_d_q <= bin_wd;
    ofw_a_q <= p2_oa_q;
    ofw_d_q <= out_wd;
  end

  assign busy_o                 = p2_v_q;
  assign res_valid_o            = p2_v_q;
  assign res_o.match            = match;
  assign res_o.found            = found_d;
  assign res_o.pattern_overflow = p2_op_q.ovf;

  a_mis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(mis_q) <= ALPHABET)
    else $error("mismatch count beyond alphabet size");

  a_empty_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_q == '0) |-> (mis_q == '0))
    else $error("mismatch reported with an empty pattern");

endmodule

### rtl/core/awd_outq.sv
// Output queue: a small flip-flop FIFO of result items that decouples the
// histogram pipeline from downstream stalls. Uses awd_pkg.
module awd_outq import awd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  awd_out_t           data_i,
  input  logic               stall_i,
  output logic               valid_o,
  output awd_out_t           data_o,
  output logic [OUTQ_CW-1:0] count_o
);

  awd_out_t           mem_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_q, rd_q;
  logic [OUTQ_CW-1:0] cnt_q, cnt_d;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + OUTQ_CW'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - OUTQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + OUTQ_AW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + OUTQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign count_o = cnt_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (32'(cnt_q) < OUTQ_DEPTH || pop))
    else $error("result queue written while full");

endmodule

### rtl/core/anagram_window_detector.sv
// Top level of the anagram window detector: input handshake, front stage,
// histogram stage and output queue. Uses awd_pkg, awd_front, awd_hist, awd_outq.
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid_i / in_stall_o  in_item_i   (func, symbol)
//   result    out        out_valid_o / out_stall_i out_item_o (match, found,
//                                                            pattern_overflow)
//
// Every accepted item yields exactly one result item; while in_stall_o is low, one
// item can be accepted in every cycle.
// The path runs through the delay-line read, then the histogram memory
// read-modify-write and then the result queue.
// Reset is asynchronous and active low; no clearing pass is needed, so items
// are accepted as soon as reset is released.
// in_stall_o rises only when the four-entry result queue plus the items in
// flight would fill up, that is when the result side stalls for a while.
module anagram_window_detector import awd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  awd_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output awd_out_t out_item_o
);

  logic               in_acc;
  logic               op_valid;
  awd_op_t            op;
  logic [BIN_AW-1:0]  old_sym;
  logic               hist_busy;
  logic               res_valid;
  awd_out_t           res;
  logic [OUTQ_CW-1:0] q_count;
  logic [OUTQ_CW:0]   pending;

  // Credit check: an item is only taken if its result has a queue slot,
  // counting the results already queued and the items still in the pipeline.
  assign pending    = (OUTQ_CW + 1)'(q_count) + (OUTQ_CW + 1)'(op_valid)
                    + (OUTQ_CW + 1)'(hist_busy);
  assign in_stall_o = (pending >= (OUTQ_CW + 1)'(OUTQ_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;

  // Decode, control counters and the text delay line.
  awd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .item_i     (in_item_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .old_o      (old_sym)
  );

  // Histogram memories and the running mismatch count between the pattern
  // and the window; a match is a full window with no mismatching bin.
  awd_hist u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .old_i       (old_sym),
    .busy_o      (hist_busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result queue toward the consumer.
  awd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (out_item_o),
    .count_o (q_count)
  );

endmodule

### tb/awd_checker.sv
`timescale 1ns / 100ps
// Result checker for the anagram window detector: it watches both channels, keeps its
// own histogram model of the block and compares every result item with it.
// Depends on awd_pkg only.
module awd_checker import awd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  awd_in_t  in_item_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  awd_out_t out_item_i,
  output int       fail_count_o,
  output int       pending_o,
  output int       results_o,
  output int       matches_o
);

  localparam int MAX_REPORTS = 10;

  // Model state at the widths of the block.
  logic [CNT_W-1:0] pat_hist [ALPHABET];
  logic [CNT_W-1:0] win_hist [ALPHABET];
  logic [SYM_W-1:0] recent   [PATTERN_MAX];
  logic [CNT_W-1:0] pat_len;
  logic [CNT_W-1:0] text_cnt;
  logic             found_r;
  logic             ovf_r;

  awd_out_t window_flags_q [$];
  int       fails       = 0;
  int       results     = 0;
  int       match_total = 0;

  function automatic void clear_window_model();
    int b;
    for (b = 0; b < ALPHABET; b++) begin
      pat_hist[b] = '0;
      win_hist[b] = '0;
    end
    for (b = 0; b < PATTERN_MAX; b++) recent[b] = '0;
    pat_len  = '0;
    text_cnt = '0;
    found_r  = 1'b0;
    ovf_r    = 1'b0;
  endfunction

  // Applies one input item to the model and returns the flags it should produce.
  function automatic awd_out_t predict_window_flags(input awd_in_t item);
    awd_out_t res;
    logic     hit;
    int       b;
    int       old;
    hit = 1'b0;
    case (item.func)
      FUNC_CLEAR: begin
        clear_window_model();
      end
      FUNC_PATTERN: begin
        if (item.symbol < ALPHABET) begin
          if (pat_len >= PATTERN_MAX) begin
            ovf_r = 1'b1;
          end else begin
            pat_hist[item.symbol]++;
            pat_len++;
            for (b = 0; b < ALPHABET; b++) win_hist[b] = '0;
            text_cnt = '0;
          end
        end
      end
      FUNC_TEXT: begin
        if (item.symbol < ALPHABET) begin
          if (pat_len > 0) begin
            if (text_cnt >= pat_len) begin
              old = recent[pat_len - 1];
              if (old < ALPHABET && win_hist[old] > 0) win_hist[old]--;
            end
            win_hist[item.symbol]++;
            for (b = PATTERN_MAX - 1; b > 0; b--) recent[b] = recent[b - 1];
            recent[0] = item.symbol;
            if (text_cnt < pat_len) text_cnt++;
          end
          hit = (text_cnt >= pat_len);
          for (b = 0; b < ALPHABET; b++) begin
            if (pat_hist[b] != win_hist[b]) hit = 1'b0;
          end
          if (hit) found_r = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.match            = hit;
    res.found            = found_r;
    res.pattern_overflow = ovf_r;
    return res;
  endfunction

  always @(posedge clk_i) begin
    awd_out_t want;
    if (!rst_ni) begin
      clear_window_model();
      window_flags_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        window_flags_q.push_back(predict_window_flags(in_item_i));
      end
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (out_item_i.match === 1'b1) match_total++;
        if (window_flags_q.size() == 0) begin
          if (fails < MAX_REPORTS) begin
            $display("%0t: result item arrived with nothing expected: match %b found %b ovf %b",
                     $time, out_item_i.match, out_item_i.found, out_item_i.pattern_overflow);
          end
          fails++;
        end else begin
          want = window_flags_q.pop_front();
          if (out_item_i.match !== want.match || out_item_i.found !== want.found ||
              out_item_i.pattern_overflow !== want.pattern_overflow) begin
            if (fails < MAX_REPORTS) begin
              $display("%0t: flags differ: expected match %b found %b ovf %b, got %b %b %b",
                       $time, want.match, want.found, want.pattern_overflow,
                       out_item_i.match, out_item_i.found, out_item_i.pattern_overflow);
            end
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= window_flags_q.size();
    results_o    <= results;
    matches_o    <= match_total;
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the anagram window detector testbench: clock, reset, input stimulus and
// result-side stalls, watchdog and verdict. Depends on awd_pkg and awd_checker.
module testbench;
  import awd_pkg::*;

  // Function code that the block must ignore; the package names only the used ones.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int ITEM_TARGET    = 1650;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  awd_in_t  in_item_i;
  logic     out_valid_o;
  logic     out_stall_i;
  awd_out_t out_item_o;

  int fail_count;
  int pending;
  int results;
  int match_total;

  // Module-level state; idle_on and hold_request are shared by sender and receiver.
  bit idle_on      = 1'b1;  // random idling on both sides
  bit hold_request = 1'b0;  // sender asks the receiver for a long hold-off
  int items_sent   = 0;     // every accepted item
  int useful_items = 0;     // accepted items that the block does not simply ignore
  int stalled_in   = 0;     // cycles the block pushed back on a waiting item

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  anagram_window_detector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  awd_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .matches_o    (match_total)
  );

  // Offers one item and returns at the edge where the block takes it. Idle cycles
  // go in front of the item, never while it waits, so a stalled payload holds still.
  // Each step gets exactly one assignment to in_valid_i.
  task automatic offer_item(input logic [1:0] func, input logic [SYM_W-1:0] sym);
    while (idle_on && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{func: func, symbol: sym};
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (func != FUNC_UNUSED && (func == FUNC_CLEAR || sym < ALPHABET)) useful_items++;
  endtask

  // Now and then slips an item into a well-formed sequence that the block should
  // skip: the unused function code, or a symbol outside the alphabet.
  task automatic sprinkle_noise();
    int pick;
    pick = $urandom_range(99);
    if (pick < 2) begin
      offer_item(FUNC_UNUSED, SYM_W'($urandom_range(0, 31)));
    end else if (pick < 4) begin
      offer_item(2'($urandom_range(1, 2)), SYM_W'($urandom_range(ALPHABET, 31)));
    end
  endtask

  // Result side. Random stalls while idling is on; when the sender asks, one long
  // hold-off counted here, during which the sender keeps offering items until the
  // result queue fills and the block stalls its input.
  initial begin : result_side
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 34);
      end
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (in_valid_i && in_stall_o) stalled_in++;
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int               span;
    int               base;
    int               roll;
    int               plen;
    int               wlen;
    int               text_len;
    int               sent;
    int               i;
    int               k;
    int               scenario;
    int               next_hold_at;
    logic [SYM_W-1:0] letter;
    logic [SYM_W-1:0] word [PATTERN_MAX];

    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    rst_ni     <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. With nothing loaded the window is empty, so any text letter
    // matches; out-of-alphabet letters and the unused code must leave all state alone.
    offer_item(FUNC_CLEAR, 5'd0);
    offer_item(FUNC_TEXT, 5'd0);
    offer_item(FUNC_UNUSED, 5'd31);
    offer_item(FUNC_TEXT, 5'd31);
    offer_item(FUNC_CLEAR, 5'd31);
    // Pattern "az" with a stray symbol in the middle, then text that fills the window,
    // matches as "za" and again as "az", then slides off.
    offer_item(FUNC_PATTERN, 5'd0);
    offer_item(FUNC_PATTERN, 5'd31);
    offer_item(FUNC_PATTERN, 5'd25);
    offer_item(FUNC_TEXT, 5'd25);
    offer_item(FUNC_TEXT, 5'd0);
    offer_item(FUNC_TEXT, 5'd25);
    offer_item(FUNC_TEXT, 5'd1);
    // A pattern letter after text restarts the scan but keeps the found flag.
    offer_item(FUNC_PATTERN, 5'd1);
    offer_item(FUNC_TEXT, 5'd1);
    offer_item(FUNC_TEXT, 5'd0);
    offer_item(FUNC_TEXT, 5'd25);
    offer_item(FUNC_UNUSED, 5'd0);
    offer_item(FUNC_TEXT, 5'd30);
    offer_item(FUNC_TEXT, 5'd26);
    offer_item(FUNC_CLEAR, 5'd0);

    // Random part. Most scenarios are a clear, a short pattern drawn from a few
    // neighboring letters, and text built from shuffled copies of the pattern and
    // loose letters of the same set, so windows match often. A few load long
    // patterns or overflow the pattern store; the rest is unstructured noise.
    scenario     = 0;
    next_hold_at = 400;
    while (useful_items < ITEM_TARGET) begin
      // One long stretch with no idling on either side.
      idle_on = !(useful_items >= 800 && useful_items < 1000);
      if (useful_items >= next_hold_at) begin
        hold_request = 1'b1;
        next_hold_at += 900;
      end
      if ($urandom_range(99) < 82) begin
        if ($urandom_range(9) < 8) offer_item(FUNC_CLEAR, SYM_W'($urandom_range(0, 31)));
        span = $urandom_range(1, 4);
        base = $urandom_range(0, ALPHABET - span);
        roll = $urandom_range(99);
        if (scenario == 3) roll = 99;
        if (roll < 5) begin
          plen = 0;
        end else if (roll < 92) begin
          plen = $urandom_range(1, 6);
        end else if (roll < 97) begin
          plen = $urandom_range(7, PATTERN_MAX);
        end else begin
          // More letters than the pattern store holds; the extra ones are dropped.
          plen = PATTERN_MAX + $urandom_range(1, 4);
        end
        if (scenario == 6) plen = PATTERN_MAX;
        for (i = 0; i < plen; i++) begin
          letter = SYM_W'(base + $urandom_range(0, span - 1));
          if (i < PATTERN_MAX) word[i] = letter;
          offer_item(FUNC_PATTERN, letter);
          sprinkle_noise();
        end
        wlen     = (plen > PATTERN_MAX) ? PATTERN_MAX : plen;
        text_len = wlen + $urandom_range(2, 2 * wlen + 10);
        sent     = 0;
        while (sent < text_len) begin
          if (wlen > 0 && $urandom_range(1) == 1) begin
            for (i = wlen - 1; i > 0; i--) begin
              k       = $urandom_range(0, i);
              letter  = word[i];
              word[i] = word[k];
              word[k] = letter;
            end
            for (i = 0; i < wlen; i++) offer_item(FUNC_TEXT, word[i]);
            sent += wlen;
          end else begin
            offer_item(FUNC_TEXT, SYM_W'(base + $urandom_range(0, span - 1)));
            sent++;
          end
          sprinkle_noise();
        end
      end else begin
        repeat ($urandom_range(4, 16)) begin
          offer_item(2'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 31)));
        end
      end
      scenario++;
    end
    in_valid_i <= 1'b0;

    // Drain: every result must come back, then a few quiet cycles for strays.
    // The checker's counters are registered, so the loop waits on the clock before looking.
    idle_on = 1'b1;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items (%0d not ignored) in %0d search scenarios and noise bursts.",
             items_sent, useful_items, scenario);
    $display("Checked %0d results, %0d with a match; input stalled for %0d cycles.",
             results, match_total, stalled_in);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/awd_pkg.sv
rtl/core/awd_ram.sv
rtl/core/awd_front.sv
rtl/core/awd_hist.sv
rtl/core/awd_outq.sv
rtl/core/anagram_window_detector.sv
tb/awd_checker.sv
tb/testbench.sv
